// File: sv/swsr_pkg.sv
// Shared types and constants for the single-wire sensor reader.
`timescale 1ns / 1ps
package swsr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_LOW_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_HIGH_WAIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_FRAME  = 3'd5;

  localparam logic [15:0] RST_START_LOW     = 16'd20000;
  localparam logic [7:0]  RST_RELEASE_HIGH  = 8'd20;
  localparam logic [7:0]  RST_ACK_LOW_WAIT  = 8'd40;
  localparam logic [7:0]  RST_ACK_HIGH_WAIT = 8'd80;
  localparam logic [7:0]  RST_BIT_SAMPLE    = 8'd40;
  localparam logic [3:0]  RST_BYTES_FRAME   = 4'd5;

  localparam logic [1:0] ACK_OK       = 2'd0;
  localparam logic [1:0] ACK_NOT_LOW  = 2'd1;
  localparam logic [1:0] ACK_NOT_HIGH = 2'd2;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_high_ticks;
    logic [7:0]  ack_low_wait_ticks;
    logic [7:0]  ack_high_wait_ticks;
    logic [7:0]  bit_sample_ticks;
    logic [3:0]  bytes_per_frame;
  } swsr_cfg_t;

  typedef struct packed {
    logic tick_enable;
    logic start_request;
    logic line_level;
  } swsr_in_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       status_valid;
    logic [1:0] ack_status;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       byte_last;
  } swsr_out_t;

endpackage

// File: sv/single_wire_sensor_reader_core.sv
// Top level: configuration registers, sequencer and registered result channel.
// Latency: an accepted item's result is presented in the cycle after acceptance.
// Throughput: one item per cycle; in_ready stays high while the result register
// is empty or being emptied in the same cycle.
// Reset: synchronous active-low rst_n returns the sequencer to idle, clears its
// counters, empties the result register and reloads every register default.
`timescale 1ns / 1ps
module single_wire_sensor_reader_core import swsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  swsr_in_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swsr_out_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  swsr_cfg_t cfg_r;
  swsr_out_t step_res;
  swsr_out_t out_item_r;
  logic      out_valid_r;
  logic      in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks     <= RST_START_LOW;
      cfg_r.release_high_ticks  <= RST_RELEASE_HIGH;
      cfg_r.ack_low_wait_ticks  <= RST_ACK_LOW_WAIT;
      cfg_r.ack_high_wait_ticks <= RST_ACK_HIGH_WAIT;
      cfg_r.bit_sample_ticks    <= RST_BIT_SAMPLE;
      cfg_r.bytes_per_frame     <= RST_BYTES_FRAME;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_LOW:     cfg_r.start_low_ticks     <= cfg_data;
        REG_RELEASE_HIGH:  cfg_r.release_high_ticks  <= cfg_data[7:0];
        REG_ACK_LOW_WAIT:  cfg_r.ack_low_wait_ticks  <= cfg_data[7:0];
        REG_ACK_HIGH_WAIT: cfg_r.ack_high_wait_ticks <= cfg_data[7:0];
        REG_BIT_SAMPLE:    cfg_r.bit_sample_ticks    <= cfg_data[7:0];
        REG_BYTES_FRAME:   cfg_r.bytes_per_frame     <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  swsr_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_accept),
    .item    (in_item),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item_r <= step_res;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.status_valid && out_item_r.byte_valid))
    else $error("status and byte reported together");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.drive_enable) |-> out_item_r.busy_res)
    else $error("line driven while idle");

endmodule

// File: sv/swsr_fsm.sv
// Line sequencer: start pulse, acknowledge check and bit reception, one step per item.
`timescale 1ns / 1ps
module swsr_fsm import swsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  swsr_in_t  item,
  input  swsr_cfg_t cfg,
  output swsr_out_t res
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_LOW  = 4'd1,
    PH_START_HIGH = 4'd2,
    PH_ACK_LOW    = 4'd3,
    PH_ACK_HIGH   = 4'd4,
    PH_ACK_FALL   = 4'd5,
    PH_BIT_RISE   = 4'd6,
    PH_BIT_DELAY  = 4'd7,
    PH_BIT_FALL   = 4'd8
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [2:0]  byte_index_r, byte_index_nxt;
  logic [1:0]  status_hold_r, status_hold_nxt;

  logic [16:0] tick_sum;
  logic [15:0] target;
  logic        wait_end;
  logic [3:0]  frame;
  logic [3:0]  byte_count;

  always_comb begin
    unique case (phase_r)
      PH_START_LOW:  target = cfg.start_low_ticks;
      PH_START_HIGH: target = {8'd0, cfg.release_high_ticks};
      PH_ACK_LOW:    target = {8'd0, cfg.ack_low_wait_ticks};
      PH_ACK_HIGH:   target = {8'd0, cfg.ack_high_wait_ticks};
      PH_BIT_DELAY:  target = {8'd0, cfg.bit_sample_ticks};
      default:       target = 16'd0;
    endcase
  end

  assign tick_sum   = {1'b0, tick_count_r} + {16'd0, item.tick_enable};
  assign wait_end   = tick_sum >= {1'b0, target};
  assign byte_count = {1'b0, byte_index_r} + 4'd1;

  always_comb begin
    if (cfg.bytes_per_frame == 4'd0) begin
      frame = 4'd1;
    end else if (cfg.bytes_per_frame > 4'd8) begin
      frame = 4'd8;
    end else begin
      frame = cfg.bytes_per_frame;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    shift_byte_nxt  = shift_byte_r;
    bit_index_nxt   = bit_index_r;
    byte_index_nxt  = byte_index_r;
    status_hold_nxt = status_hold_r;
    res             = '0;

    unique case (phase_r)
      PH_START_LOW, PH_START_HIGH, PH_ACK_LOW, PH_ACK_HIGH, PH_BIT_DELAY: begin
        tick_count_nxt = wait_end ? 16'd0 : tick_sum[15:0];
      end
      default: begin
      end
    endcase

    unique case (phase_r)
      PH_START_LOW: begin
        if (wait_end) phase_nxt = PH_START_HIGH;
      end
      PH_START_HIGH: begin
        if (wait_end) phase_nxt = PH_ACK_LOW;
      end
      PH_ACK_LOW: begin
        if (wait_end) begin
          if (!item.line_level) begin
            phase_nxt = PH_ACK_HIGH;
          end else begin
            status_hold_nxt  = ACK_NOT_LOW;
            res.status_valid = 1'b1;
            res.ack_status   = ACK_NOT_LOW;
            phase_nxt        = PH_ACK_FALL;
          end
        end
      end
      PH_ACK_HIGH: begin
        if (wait_end) begin
          status_hold_nxt  = item.line_level ? ACK_OK : ACK_NOT_HIGH;
          res.status_valid = 1'b1;
          res.ack_status   = item.line_level ? ACK_OK : ACK_NOT_HIGH;
          phase_nxt        = PH_ACK_FALL;
        end
      end
      PH_ACK_FALL: begin
        if (!item.line_level) begin
          if (status_hold_r == ACK_OK) begin
            bit_index_nxt  = 3'd0;
            byte_index_nxt = 3'd0;
            shift_byte_nxt = 8'd0;
            phase_nxt      = PH_BIT_RISE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_BIT_RISE: begin
        if (item.line_level) begin
          tick_count_nxt = 16'd0;
          phase_nxt      = PH_BIT_DELAY;
        end
      end
      PH_BIT_DELAY: begin
        if (wait_end) begin
          shift_byte_nxt = {shift_byte_r[6:0], item.line_level};
          phase_nxt      = PH_BIT_FALL;
        end
      end
      PH_BIT_FALL: begin
        if (!item.line_level) begin
          if (bit_index_r == 3'd7) begin
            bit_index_nxt  = 3'd0;
            res.byte_valid = 1'b1;
            res.data_byte  = shift_byte_r;
            if (byte_count >= frame) begin
              res.byte_last  = 1'b1;
              byte_index_nxt = 3'd0;
              phase_nxt      = PH_IDLE;
            end else begin
              byte_index_nxt = byte_count[2:0];
              phase_nxt      = PH_BIT_RISE;
            end
          end else begin
            bit_index_nxt = bit_index_r + 3'd1;
            phase_nxt     = PH_BIT_RISE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (item.start_request) begin
          tick_count_nxt  = 16'd0;
          status_hold_nxt = ACK_OK;
          phase_nxt       = PH_START_LOW;
        end
      end
    endcase

    res.drive_enable = (phase_nxt == PH_START_LOW) || (phase_nxt == PH_START_HIGH);
    res.drive_level  = (phase_nxt == PH_START_HIGH);
    res.busy_res     = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= 16'd0;
      shift_byte_r  <= 8'd0;
      bit_index_r   <= 3'd0;
      byte_index_r  <= 3'd0;
      status_hold_r <= ACK_OK;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      shift_byte_r  <= shift_byte_nxt;
      bit_index_r   <= bit_index_nxt;
      byte_index_r  <= byte_index_nxt;
      status_hold_r <= status_hold_nxt;
    end
  end

endmodule

// File: tb/single_wire_sensor_reader_core_tb.sv
// Self-checking testbench for the single-wire sensor reader core with a cycle-level predictor.
`timescale 1ns / 1ps
module single_wire_sensor_reader_core_tb;
  import swsr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_EVERY = 211;
  localparam int TAIL_CYCLES = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_START_LOW, S_START_HIGH, S_ACK_LOW, S_ACK_HIGH, S_ACK_FALL,
    S_BIT_RISE, S_BIT_DELAY, S_BIT_FALL
  } rdr_phase_t;

  typedef struct packed {
    rdr_phase_t  ph;
    logic [15:0] ticks;
    logic [7:0]  shreg;
    logic [2:0]  bit_n;
    logic [2:0]  byte_n;
    logic [1:0]  ack_hold;
  } rdr_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  swsr_in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  swsr_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  swsr_cfg_t regs = '{RST_START_LOW, RST_RELEASE_HIGH, RST_ACK_LOW_WAIT,
                      RST_ACK_HIGH_WAIT, RST_BIT_SAMPLE, RST_BYTES_FRAME};
  rdr_state_t rdr_now;
  rdr_state_t rdr_ahead;
  swsr_in_t sample_q[$];
  swsr_out_t due_q[$];
  logic [1:0] plan_q[$];
  bit bit_q[$];
  logic [1:0] ack_plan = ACK_OK;
  swsr_out_t head;
  int src_idle = 0;
  int sink_idle = 0;
  int fed = 0;
  bit drain_hold = 1'b0;
  int fail_cnt = 0;
  int stall_cnt = 0;

  single_wire_sensor_reader_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic rdr_state_t idle_state();
    rdr_state_t s;
    s.ph = S_IDLE;
    s.ticks = '0;
    s.shreg = '0;
    s.bit_n = '0;
    s.byte_n = '0;
    s.ack_hold = ACK_OK;
    return s;
  endfunction

  function automatic bit wait_ends(input logic [15:0] cnt, input logic tk,
                                   input logic [15:0] target);
    return ({1'b0, cnt} + {16'd0, tk}) >= {1'b0, target};
  endfunction

  function automatic bit count_wait(inout logic [15:0] cnt, input logic tk,
                                    input logic [15:0] target);
    if (wait_ends(cnt, tk, target)) begin
      cnt = '0;
      return 1'b1;
    end
    cnt = cnt + {15'd0, tk};
    return 1'b0;
  endfunction

  function automatic swsr_out_t reader_step(inout rdr_state_t s, input swsr_in_t x);
    swsr_out_t r;
    int frame;
    r = '0;
    frame = regs.bytes_per_frame;
    if (frame == 0) frame = 1;
    if (frame > 8) frame = 8;
    case (s.ph)
      S_START_LOW: begin
        if (count_wait(s.ticks, x.tick_enable, regs.start_low_ticks)) s.ph = S_START_HIGH;
      end
      S_START_HIGH: begin
        if (count_wait(s.ticks, x.tick_enable, {8'd0, regs.release_high_ticks}))
          s.ph = S_ACK_LOW;
      end
      S_ACK_LOW: begin
        if (count_wait(s.ticks, x.tick_enable, {8'd0, regs.ack_low_wait_ticks})) begin
          if (!x.line_level) begin
            s.ph = S_ACK_HIGH;
          end else begin
            s.ack_hold = ACK_NOT_LOW;
            r.status_valid = 1'b1;
            r.ack_status = ACK_NOT_LOW;
            s.ph = S_ACK_FALL;
          end
        end
      end
      S_ACK_HIGH: begin
        if (count_wait(s.ticks, x.tick_enable, {8'd0, regs.ack_high_wait_ticks})) begin
          s.ack_hold = x.line_level ? ACK_OK : ACK_NOT_HIGH;
          r.status_valid = 1'b1;
          r.ack_status = s.ack_hold;
          s.ph = S_ACK_FALL;
        end
      end
      S_ACK_FALL: begin
        if (!x.line_level) begin
          if (s.ack_hold == ACK_OK) begin
            s.bit_n = '0;
            s.byte_n = '0;
            s.shreg = '0;
            s.ph = S_BIT_RISE;
          end else begin
            s.ph = S_IDLE;
          end
        end
      end
      S_BIT_RISE: begin
        if (x.line_level) begin
          s.ticks = '0;
          s.ph = S_BIT_DELAY;
        end
      end
      S_BIT_DELAY: begin
        if (count_wait(s.ticks, x.tick_enable, {8'd0, regs.bit_sample_ticks})) begin
          s.shreg = {s.shreg[6:0], x.line_level};
          s.ph = S_BIT_FALL;
        end
      end
      S_BIT_FALL: begin
        if (!x.line_level) begin
          if (s.bit_n == 3'd7) begin
            s.bit_n = '0;
            r.byte_valid = 1'b1;
            r.data_byte = s.shreg;
            if (int'(s.byte_n) + 1 >= frame) begin
              r.byte_last = 1'b1;
              s.byte_n = '0;
              s.ph = S_IDLE;
            end else begin
              s.byte_n = s.byte_n + 3'd1;
              s.ph = S_BIT_RISE;
            end
          end else begin
            s.bit_n = s.bit_n + 3'd1;
            s.ph = S_BIT_RISE;
          end
        end
      end
      default: begin
        s.ph = S_IDLE;
        if (x.start_request) begin
          s.ticks = '0;
          s.ack_hold = ACK_OK;
          s.ph = S_START_LOW;
        end
      end
    endcase
    r.drive_enable = (s.ph == S_START_LOW) || (s.ph == S_START_HIGH);
    r.drive_level = (s.ph == S_START_HIGH);
    r.busy_res = (s.ph != S_IDLE);
    return r;
  endfunction

  // Play the sensor side of the bus against the look-ahead copy of the reader.
  function automatic swsr_in_t next_stim(input bit may_start, input int noise_pct,
                                         input int tick_pct);
    swsr_in_t it;
    it.tick_enable = ($urandom_range(99) < tick_pct);
    it.start_request = may_start && ($urandom_range(3) == 0);
    it.line_level = 1'($urandom_range(1));
    if (!(may_start && ($urandom_range(99) < noise_pct))) begin
      case (rdr_ahead.ph)
        S_ACK_LOW: begin
          if (wait_ends(rdr_ahead.ticks, it.tick_enable, {8'd0, regs.ack_low_wait_ticks}))
            it.line_level = (ack_plan == ACK_NOT_LOW);
        end
        S_ACK_HIGH: begin
          if (wait_ends(rdr_ahead.ticks, it.tick_enable, {8'd0, regs.ack_high_wait_ticks}))
            it.line_level = (ack_plan != ACK_NOT_HIGH);
        end
        S_ACK_FALL: it.line_level = ($urandom_range(2) != 0);
        S_BIT_RISE: it.line_level = 1'($urandom_range(1));
        S_BIT_DELAY: begin
          if (wait_ends(rdr_ahead.ticks, it.tick_enable, {8'd0, regs.bit_sample_ticks})) begin
            if (bit_q.size() != 0) it.line_level = bit_q.pop_front();
            else it.line_level = 1'($urandom_range(1));
          end
        end
        S_BIT_FALL: it.line_level = 1'($urandom_range(1));
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic add_item(input swsr_in_t it);
    int pick;
    if (rdr_ahead.ph == S_IDLE && it.start_request) begin
      pick = $urandom_range(9);
      if (plan_q.size() != 0) ack_plan = plan_q.pop_front();
      else if (pick == 0) ack_plan = ACK_NOT_LOW;
      else if (pick == 1) ack_plan = ACK_NOT_HIGH;
      else ack_plan = ACK_OK;
    end
    void'(reader_step(rdr_ahead, it));
    sample_q.push_back(it);
  endtask

  task automatic make_items(input int count, input int noise_pct, input int tick_pct);
    int made;
    made = 0;
    while (made < count || rdr_ahead.ph != S_IDLE) begin
      add_item(next_stim(made < count, noise_pct, tick_pct));
      made++;
    end
  endtask

  task automatic start_frame(input logic [1:0] ack, input int tick_pct);
    swsr_in_t it;
    it.tick_enable = 1'($urandom_range(1));
    it.start_request = 1'b1;
    it.line_level = 1'($urandom_range(1));
    plan_q.push_back(ack);
    add_item(it);
    make_items(0, 0, tick_pct);
  endtask

  task automatic plan_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) bit_q.push_back(b[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_LOW:     regs.start_low_ticks = val;
      REG_RELEASE_HIGH:  regs.release_high_ticks = val[7:0];
      REG_ACK_LOW_WAIT:  regs.ack_low_wait_ticks = val[7:0];
      REG_ACK_HIGH_WAIT: regs.ack_high_wait_ticks = val[7:0];
      REG_BIT_SAMPLE:    regs.bit_sample_ticks = val[7:0];
      REG_BYTES_FRAME:   regs.bytes_per_frame = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input logic [15:0] lo, input logic [7:0] rel, input logic [7:0] al,
                          input logic [7:0] ah, input logic [7:0] bs, input logic [3:0] nb);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_START_LOW, lo);
    write_reg(REG_RELEASE_HIGH, {junk[15:8], rel});
    write_reg(REG_ACK_LOW_WAIT, {junk[7:0], al});
    write_reg(REG_ACK_HIGH_WAIT, {junk[11:4], ah});
    write_reg(REG_BIT_SAMPLE, {junk[3:0], junk[15:12], bs});
    write_reg(REG_BYTES_FRAME, {junk[11:0], nb});
    junk = 16'($urandom);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, junk);
  endtask

  task automatic wait_quiet();
    while (sample_q.size() != 0 || in_valid || due_q.size() != 0 || drain_hold)
      @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (fail_cnt < 10) $display("%s: expected %0h, actual %0h", what, want, got);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_q.push_back(reader_step(rdr_now, in_item));
        fed++;
        if (fed % DRAIN_EVERY == 0) drain_hold = 1'b1;
      end
      if (drain_hold && !in_valid && due_q.size() == 0) drain_hold = 1'b0;
      if (!in_valid || in_ready) begin
        if (!drain_hold && sample_q.size() != 0 && $urandom_range(99) >= src_idle) begin
          in_valid <= 1'b1;
          in_item <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          flag_mismatch("result with none due", '0, out_item);
        end else begin
          head = due_q.pop_front();
          if (out_item.drive_enable !== head.drive_enable)
            flag_mismatch("drive_enable", 16'(head.drive_enable), 16'(out_item.drive_enable));
          if (out_item.drive_level !== head.drive_level)
            flag_mismatch("drive_level", 16'(head.drive_level), 16'(out_item.drive_level));
          if (out_item.busy_res !== head.busy_res)
            flag_mismatch("busy_res", 16'(head.busy_res), 16'(out_item.busy_res));
          if (out_item.status_valid !== head.status_valid)
            flag_mismatch("status_valid", 16'(head.status_valid), 16'(out_item.status_valid));
          if (out_item.ack_status !== head.ack_status)
            flag_mismatch("ack_status", 16'(head.ack_status), 16'(out_item.ack_status));
          if (out_item.byte_valid !== head.byte_valid)
            flag_mismatch("byte_valid", 16'(head.byte_valid), 16'(out_item.byte_valid));
          if (out_item.data_byte !== head.data_byte)
            flag_mismatch("data_byte", 16'(head.data_byte), 16'(out_item.data_byte));
          if (out_item.byte_last !== head.byte_last)
            flag_mismatch("byte_last", 16'(head.byte_last), 16'(out_item.byte_last));
        end
      end
      out_ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("single_wire_sensor_reader_core_tb failed");
      $finish;
    end
  end

  initial begin
    rdr_now = idle_state();
    rdr_ahead = idle_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    src_idle = 32;
    sink_idle = 86;
    write_reg(REG_START_LOW, 16'd2);
    write_reg(REG_BIT_SAMPLE, 16'd1);
    write_reg(REG_BYTES_FRAME, 16'd1);
    plan_byte(8'hA5);
    start_frame(ACK_OK, 100);
    wait_quiet();

    load_cfg(16'd2, 8'd1, 8'd1, 8'd1, 8'd1, 4'd1);
    start_frame(ACK_NOT_LOW, 70);
    start_frame(ACK_NOT_HIGH, 70);
    plan_byte(8'hFF);
    start_frame(ACK_OK, 70);
    wait_quiet();

    load_cfg(16'd3, 8'd2, 8'd0, 8'd0, 8'd0, 4'd0);
    plan_byte(8'h00);
    start_frame(ACK_OK, 70);
    start_frame(ACK_NOT_HIGH, 70);
    wait_quiet();

    load_cfg(16'd1, 8'd1, 8'd1, 8'd1, 8'd1, 4'd15);
    plan_byte(8'h01);
    plan_byte(8'hFE);
    plan_byte(8'h5A);
    plan_byte(8'h80);
    start_frame(ACK_OK, 80);
    wait_quiet();

    load_cfg(16'd4, 8'd3, 8'd5, 8'd6, 8'd3, 4'd2);
    make_items(60, 15, 75);
    wait_quiet();

    src_idle = 86;
    sink_idle = 32;
    load_cfg(16'd1, 8'd2, 8'd3, 8'd2, 8'd4, 4'd1);
    make_items(50, 15, 75);
    wait_quiet();

    src_idle = 0;
    sink_idle = 0;
    load_cfg(16'd5, 8'd1, 8'd2, 8'd1, 8'd2, 4'd3);
    make_items(60, 10, 60);
    wait_quiet();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && due_q.size() == 0)
      $display("single_wire_sensor_reader_core_tb passed");
    else
      $display("single_wire_sensor_reader_core_tb failed");
    $finish;
  end

endmodule
